// ----- rtl/ldbr_pkg.sv -----
// Shared constants for the longest distinct byte run block.
package ldbr_pkg;

    localparam int CHAR_W       = 8;
    localparam int LEN_W        = 9;
    localparam int ALPHABET_DEF = 256;
    localparam int MAX_LEN_DEF  = 65536;

endpackage

// ----- rtl/longest_distinct_byte_run.sv -----
// Longest run of distinct bytes in a streamed string.
//
// Input channel: one string byte per beat (i_char_byte), with i_end_of_string
// set on the final byte. A beat is taken when i_valid is high and o_stall low.
// Output channel: one result beat per string (o_longest_length, o_too_long),
// taken when o_valid is high and i_stall low. o_too_long flags a string longer
// than MAX_LEN bytes; bytes past that limit are dropped from the window.
// Throughput: one byte per cycle while o_stall is low. Each byte costs one
// read of the last-seen position memory on accept and, within MAX_LEN, one
// write from stage 1; a byte that hits the value written by its predecessor
// takes the forwarded position. Results pass stage 1, then the output register.
// The output register lets a new string stream in while a result waits; only
// a second final byte meeting a still-stalled result raises o_stall.
// Reset (synchronous, active low) clears the window, counters, the valid bit
// of every byte value and both pipeline stages; the position memory needs no
// clearing. A final byte returns the window, counters and valid bits to reset.
module longest_distinct_byte_run #(
    parameter int MAX_LEN  = ldbr_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = ldbr_pkg::ALPHABET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ldbr_pkg::CHAR_W-1:0] i_char_byte,
    input  logic                        i_end_of_string,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ldbr_pkg::LEN_W-1:0]  o_longest_length,
    output logic                        o_too_long
);

    localparam int AW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BPW = $clog2(MAX_LEN + 1);
    localparam int LW  = ldbr_pkg::LEN_W;

    typedef logic [AW-1:0] t_idx;
    typedef logic [PW-1:0] t_pos;

    // last-seen position per byte value
    t_pos mem_pos [ALPHABET];

    logic                r_s1_valid;
    t_idx                r_s1_idx;
    logic                r_s1_last;
    t_pos                r_rd_data;
    logic [ALPHABET-1:0] r_seen;
    t_pos                r_ws;
    logic [BPW-1:0]      r_byte_pos;
    logic [LW-1:0]       r_best;
    logic                r_ovf;
    logic                r_out_valid;
    logic [LW-1:0]       r_out_len;
    logic                r_out_ovf;

    logic           s1_hold;
    logic           in_accept;
    logic           s1_commit;
    logic           s1_inrange;
    logic           s1_wr;
    t_idx           in_idx;
    t_pos           n_ws;
    logic [BPW-1:0] len_full;
    logic [LW-1:0]  len;
    logic [LW-1:0]  n_best;

    // hold the final byte while the previous result still waits
    assign s1_hold   = r_s1_valid && r_s1_last && r_out_valid && i_stall;
    assign o_stall   = s1_hold;
    assign in_accept = i_valid && !s1_hold;
    assign s1_commit = r_s1_valid && !s1_hold;

    assign in_idx = ({1'b0, i_char_byte} < (LW)'(ALPHABET)) ?
                    i_char_byte[AW-1:0] : (AW)'(ALPHABET - 1);

    assign s1_inrange = r_byte_pos < (BPW)'(MAX_LEN);
    assign s1_wr      = s1_commit && s1_inrange;

    always_comb begin
        n_ws = r_ws;
        if (r_seen[r_s1_idx] && (r_rd_data >= r_ws)) begin
            n_ws = r_rd_data + t_pos'(1);
        end
        len_full = r_byte_pos - (BPW)'(n_ws) + (BPW)'(1);
        len      = len_full[LW-1:0];
        n_best   = r_best;
        if (s1_inrange && (len > r_best)) begin
            n_best = len;
        end
    end

    // position memory: read on accept with forwarding, write from stage 1
    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            mem_pos[r_s1_idx] <= r_byte_pos[PW-1:0];
        end
        if (in_accept) begin
            if (s1_wr && (r_s1_idx == in_idx)) begin
                r_rd_data <= r_byte_pos[PW-1:0];
            end else begin
                r_rd_data <= mem_pos[in_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx  <= in_idx;
            r_s1_last <= i_end_of_string;
        end
        if (s1_commit && r_s1_last) begin
            r_out_len <= n_best;
            r_out_ovf <= r_ovf || !s1_inrange;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_seen      <= '0;
            r_ws        <= '0;
            r_byte_pos  <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!s1_hold) begin
                r_s1_valid <= in_accept;
            end
            if (s1_commit && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (s1_commit) begin
                if (r_s1_last) begin
                    r_seen      <= '0;
                    r_ws        <= '0;
                    r_byte_pos  <= '0;
                    r_best      <= '0;
                    r_ovf       <= 1'b0;
                end else if (s1_inrange) begin
                    r_seen[r_s1_idx] <= 1'b1;
                    r_ws             <= n_ws;
                    r_byte_pos       <= r_byte_pos + (BPW)'(1);
                    r_best           <= n_best;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_longest_length = r_out_len;
    assign o_too_long       = r_out_ovf;

    a_hold_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("stall raised without a pending final byte");

    a_end_clears_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_commit && r_s1_last) |=> (r_seen == '0) && r_out_valid)
        else $error("final byte did not clear seen flags or post a result");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (BPW)'(r_ws) <= r_byte_pos)
        else $error("window start passed byte position");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best <= (LW)'(ALPHABET))
        else $error("best length exceeds alphabet size");

endmodule

// ----- sim/longest_distinct_byte_run_test.sv -----
// Self-checking testbench for the longest distinct byte run block.
`timescale 1ns / 100ps

typedef struct packed {
    logic [ldbr_pkg::LEN_W-1:0] length;
    logic                       too_long;
} t_run_result;

// Track the sliding window of every accepted byte and queue the run each string yields.
class distinct_run_scoreboard;
    localparam int MAX_LEN  = ldbr_pkg::MAX_LEN_DEF;
    localparam int ALPHABET = ldbr_pkg::ALPHABET_DEF;

    logic [15:0]                last_pos [ALPHABET];
    bit                         seen [ALPHABET];
    logic [16:0]                win_start;
    logic [16:0]                byte_pos;
    logic [ldbr_pkg::LEN_W-1:0] best_len;
    bit                         overflow;
    t_run_result                pending_runs [$];
    int                         errors;

    function new();
        errors = 0;
        clear_window();
    endfunction

    function void clear_window();
        foreach (seen[i]) seen[i] = 0;
        win_start = '0;
        byte_pos  = '0;
        best_len  = '0;
        overflow  = 0;
    endfunction

    function void note_byte(logic [ldbr_pkg::CHAR_W-1:0] ch, logic last);
        logic [16:0] span;
        t_run_result run;
        if (byte_pos >= MAX_LEN) begin
            // drop bytes past the position range
            overflow = 1;
        end else begin
            if (seen[ch] && {1'b0, last_pos[ch]} >= win_start)
                win_start = {1'b0, last_pos[ch]} + 17'd1;
            last_pos[ch] = byte_pos[15:0];
            seen[ch]     = 1;
            span = byte_pos - win_start + 17'd1;
            if (span > best_len)
                best_len = span[ldbr_pkg::LEN_W-1:0];
            byte_pos = byte_pos + 17'd1;
        end
        if (last) begin
            run.length   = best_len;
            run.too_long = overflow;
            pending_runs.push_back(run);
            clear_window();
        end
    endfunction

    function void flag(string field, int exp_val, int act_val);
        if (errors < 50)
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
        errors++;
    endfunction

    function void check_result(logic [ldbr_pkg::LEN_W-1:0] length, logic too_long);
        t_run_result run;
        if (pending_runs.size() == 0) begin
            if (errors < 50)
                $error("result beat with no string pending: length %0d, too_long %0d",
                       length, too_long);
            errors++;
            return;
        end
        run = pending_runs.pop_front();
        if (length !== run.length)
            flag("longest_length", run.length, length);
        if (too_long !== run.too_long)
            flag("too_long", run.too_long, too_long);
    endfunction

    function int outstanding();
        return pending_runs.size();
    endfunction
endclass

module longest_distinct_byte_run_test;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 700;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [ldbr_pkg::CHAR_W-1:0]   i_char_byte;
    logic                          i_end_of_string;
    logic                          o_valid;
    logic                          i_stall;
    logic [ldbr_pkg::LEN_W-1:0]    o_longest_length;
    logic                          o_too_long;

    distinct_run_scoreboard tracker = new();

    logic [ldbr_pkg::CHAR_W-1:0]   str_q [$];
    bit                            gaps_on;
    int                            burst_left;
    int                            items_sent;
    bit                            hold_req;
    bit                            hold_taken;
    bit                            hold_done;
    t_stall_mode                   stall_mode;
    int                            mode_left;
    int                            idle_cycles;

    longest_distinct_byte_run i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_byte      (i_char_byte),
        .i_end_of_string  (i_end_of_string),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_longest_length (o_longest_length),
        .o_too_long       (o_too_long)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Drive one beat and hold it until the block takes it.
    task automatic send_byte(input logic [ldbr_pkg::CHAR_W-1:0] ch, input logic last);
        if (gaps_on) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        i_valid         = 1;
        i_char_byte     = ch;
        i_end_of_string = last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_byte(ch, last);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++) begin
            send_byte(str_q[i], i == str_q.size() - 1);
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        while (tracker.outstanding() != 0) @(negedge i_clk);
    endtask

    // Few distinct values, so repeats land inside and before the window.
    function automatic void build_narrow(int len);
        logic [ldbr_pkg::CHAR_W-1:0] pool [3];
        foreach (pool[i]) pool[i] = (ldbr_pkg::CHAR_W)'($urandom_range(0, 255));
        str_q.delete();
        repeat (len) str_q.push_back(pool[$urandom_range(0, 2)]);
    endfunction

    function automatic void build_wide(int len);
        str_q.delete();
        repeat (len) str_q.push_back((ldbr_pkg::CHAR_W)'($urandom_range(0, 255)));
    endfunction

    // Lead with a run of distinct values, then a random tail.
    function automatic void build_distinct(int count, int tail);
        logic [ldbr_pkg::CHAR_W-1:0] perm [256];
        logic [ldbr_pkg::CHAR_W-1:0] swap;
        int                          j;
        foreach (perm[i]) perm[i] = (ldbr_pkg::CHAR_W)'(i);
        for (int i = 0; i < count; i++) begin
            j       = $urandom_range(i, 255);
            swap    = perm[i];
            perm[i] = perm[j];
            perm[j] = swap;
        end
        str_q.delete();
        for (int i = 0; i < count; i++) str_q.push_back(perm[i]);
        repeat (tail) str_q.push_back((ldbr_pkg::CHAR_W)'($urandom_range(0, 255)));
    endfunction

    // Receiver: stall on its own pattern, or hold off on request.
    initial begin
        i_stall    = 0;
        mode_left  = 0;
        hold_taken = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1;
                i_stall    = 1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall = 0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(8, 80);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:   i_stall = 0;
                    STALL_LIGHT:  i_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  i_stall = ($urandom_range(0, 3) != 0);
                    default:      i_stall = !i_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_longest_length, o_too_long);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 0;
        i_valid         = 0;
        i_char_byte     = '0;
        i_end_of_string = 0;
        gaps_on         = 0;
        burst_left      = 0;
        items_sent      = 0;
        hold_req        = 0;
        hold_done       = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // single-byte strings at both ends of the byte range, then short strings with repeats
        str_q = '{8'hFF};
        send_string();
        str_q = '{8'h00};
        send_string();
        str_q = '{8'h00, 8'h00};
        send_string();
        str_q = '{8'hAA, 8'h55, 8'hAA, 8'h55};
        send_string();
        str_q = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62};
        send_string();
        // a repeat from before the window start must not pull the start back
        str_q = '{8'h61, 8'h62, 8'h62, 8'h61};
        send_string();
        str_q = '{8'h80, 8'h7F, 8'h01, 8'hFE};
        send_string();
        wait_drained();

        // full alphabet: longest run reaches its top value
        gaps_on = 1;
        build_distinct(256, 0);
        send_string();
        build_distinct(256, 1);
        send_string();

        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 350) begin
                // back up the output so the block stalls its input
                hold_req = 1;
                gaps_on  = 0;
                repeat (12) begin
                    build_narrow($urandom_range(1, 5));
                    send_string();
                end
                hold_done = 1;
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: build_narrow($urandom_range(1, 12));
                4, 5, 6:    build_wide($urandom_range(1, 30));
                7, 8:       build_distinct($urandom_range(1, 40), $urandom_range(0, 10));
                default:    build_distinct($urandom_range(100, 256), $urandom_range(0, 3));
            endcase
            send_string();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/ldbr_pkg.sv
rtl/longest_distinct_byte_run.sv
sim/longest_distinct_byte_run_test.sv
